### design/stbs_pkg.sv
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int CFG_W       = 11;
	localparam int LIDX_W      = 10;
	localparam int POS_W       = 10;
	localparam int DATA_W      = 32;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic init;
		logic load;
		logic issue;
		logic advance;
		logic finish;
		logic hit;
	} stbs_cmd_t;

	typedef struct packed {
		logic range_open;
		logic hit;
	} stbs_status_t;

endpackage

### design/stbs_dpath.sv
module stbs_dpath import stbs_pkg::*; (
	input  logic                     clk,
	input  stbs_cmd_t                cmd,
	input  logic [CNT_W-1:0]         count,
	input  logic [LIDX_W-1:0]        load_index,
	input  logic signed [DATA_W-1:0] value,
	output stbs_status_t             status,
	output logic                     found,
	output logic [POS_W-1:0]         position
);

	logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
	logic signed [DATA_W-1:0] rd_q;
	logic signed [DATA_W-1:0] key_q;
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic [IDX_W-1:0]         mid_q;
	logic [CNT_W-1:0]         diff;
	logic [CNT_W-1:0]         mid_full;
	logic [IDX_W-1:0]         mid;
	logic                     load_ok;
	logic                     found_q;
	logic [POS_W-1:0]         position_q;

	assign diff     = hi_q - lo_q;
	assign mid_full = lo_q + ((diff - CNT_W'(1)) >> 1);
	assign mid      = mid_full[IDX_W-1:0];
	assign load_ok  = 32'(load_index) < 32'(TABLE_DEPTH);

	assign status.range_open = lo_q < hi_q;
	assign status.hit        = rd_q == key_q;

	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			mem[IDX_W'(load_index)] <= value;
		end
		if (cmd.issue) begin
			rd_q <= mem[mid];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			lo_q  <= '0;
			hi_q  <= count;
			key_q <= value;
		end else if (cmd.advance) begin
			if (rd_q < key_q) begin
				lo_q <= CNT_W'(mid_q) + CNT_W'(1);
			end else begin
				hi_q <= CNT_W'(mid_q);
			end
		end
		if (cmd.issue) begin
			mid_q <= mid;
		end
		if (cmd.finish) begin
			found_q    <= cmd.hit;
			position_q <= cmd.hit ? POS_W'(mid_q) : '0;
		end
	end

	assign found    = found_q;
	assign position = position_q;

endmodule

### design/stbs_ctrl.sv
module stbs_ctrl import stbs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         action,
	input  stbs_status_t status,
	output stbs_cmd_t    cmd,
	output logic         busy,
	output logic         done
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_ISSUE   = 2'd1;
	localparam logic [1:0] ST_COMPARE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action == ACT_SEARCH) begin
						cmd.init = 1'b1;
						state_d  = ST_ISSUE;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_ISSUE: begin
				if (status.range_open) begin
					cmd.issue = 1'b1;
					state_d   = ST_COMPARE;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_COMPARE: begin
				if (status.hit) begin
					cmd.finish = 1'b1;
					cmd.hit    = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_ISSUE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;

endmodule

### design/sorted_table_binary_search_top.sv
// Sorted table binary search.
// Input word: start with action, load_index and value, taken when start is
// high and busy is low. A load (action 0) writes value into the table at
// load_index and gives no result. A search (action 1) looks for value among
// the first element_count entries, which must be loaded in ascending signed
// order beforehand.
// Config: cfg_data is written into element_count when cfg_valid and
// cfg_ready are both high; cfg_ready is always high. Write only while idle.
// A count above the table depth is treated as the full depth.
// Result word: done is high for exactly one cycle with found and position;
// position is 0 when found is 0. The receiver cannot stall.
// Search: a search keeps busy high while it halves the range; done follows in
// the next cycle, with busy low. Each halving step is an issue state, which
// registers the read of the table memory, followed by a compare state.
// Reset: arst_n clears the controller and element_count; table contents stay
// undefined until loaded.
module sorted_table_binary_search_top import stbs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     action,
	input  logic [LIDX_W-1:0]        load_index,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic                     found,
	output logic [POS_W-1:0]         position,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_W-1:0]         cfg_data
);

	logic [CFG_W-1:0] count_q;
	logic [CNT_W-1:0] count_sat;
	stbs_cmd_t        cmd;
	stbs_status_t     status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	assign count_sat = (32'(count_q) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
		: CNT_W'(count_q);

	stbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	stbs_dpath u_dpath (
		.clk        (clk),
		.cmd        (cmd),
		.count      (count_sat),
		.load_index (load_index),
		.value      (value),
		.status     (status),
		.found      (found),
		.position   (position)
	);

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a search in progress");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_LOAD) |=> !done)
		else $error("load word produced a result");

	a_miss_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> position == '0)
		else $error("nonzero position on a miss");
`endif

endmodule

### sim/tb_sorted_table_binary_search_top.sv
module tb_sorted_table_binary_search_top;
	import stbs_pkg::*;

	localparam int    WATCHDOG_LIMIT = 1000;
	localparam int    SETTLE_CYCLES  = 30;
	localparam int    NUM_PHASES     = 16;
	localparam int    SEARCHES_PER   = 8;
	localparam longint VAL_MIN       = -64'sd2147483648;
	localparam longint VAL_MAX       = 64'sd2147483647;
	localparam longint SPARSE_STEP   = 64'sd4194304;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} hit_t;

	class search_tracker;
		logic signed [DATA_W-1:0] table_copy [TABLE_DEPTH];
		bit                       written [TABLE_DEPTH];
		logic [CFG_W-1:0]         entry_count;
		hit_t                     pending_hits [$];
		int                       errors;

		function new();
			entry_count = '0;
			errors      = 0;
		endfunction

		function void set_count(logic [CFG_W-1:0] c);
			entry_count = c;
		endfunction

		function hit_t bsearch_table(logic signed [DATA_W-1:0] key);
			int   n;
			int   lo;
			int   hi;
			int   mid;
			hit_t r;
			r = '0;
			n = int'(entry_count);
			if (n > TABLE_DEPTH)
				n = TABLE_DEPTH;
			lo = 0;
			hi = n - 1;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (table_copy[mid] == key) begin
					r.found    = 1'b1;
					r.position = mid[POS_W-1:0];
					return r;
				end
				if (table_copy[mid] < key)
					lo = mid + 1;
				else
					hi = mid - 1;
			end
			return r;
		endfunction

		function void note_word(logic act, logic [LIDX_W-1:0] idx,
				logic signed [DATA_W-1:0] val);
			if (act == ACT_LOAD) begin
				table_copy[idx] = val;
				written[idx]    = 1'b1;
			end else begin
				pending_hits.push_back(bsearch_table(val));
			end
		endfunction

		function void check_result(logic f, logic [POS_W-1:0] p);
			hit_t exp_hit;
			if (pending_hits.size() == 0) begin
				$error("result with no search pending: found %0d position %0d", f, p);
				errors++;
			end else begin
				exp_hit = pending_hits.pop_front();
				if (f !== exp_hit.found) begin
					$error("found: expected %0d, actual %0d", exp_hit.found, f);
					errors++;
				end
				if (p !== exp_hit.position) begin
					$error("position: expected %0d, actual %0d", exp_hit.position, p);
					errors++;
				end
			end
		endfunction

		function int pending();
			return pending_hits.size();
		endfunction
	endclass

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic                     action     = ACT_LOAD;
	logic [LIDX_W-1:0]        load_index = '0;
	logic signed [DATA_W-1:0] value      = '0;
	logic                     cfg_valid  = 1'b0;
	logic [CFG_W-1:0]         cfg_data   = '0;
	logic                     busy;
	logic                     done;
	logic                     found;
	logic [POS_W-1:0]         position;
	logic                     cfg_ready;

	search_tracker hits = new();
	int            burst_left = 0;
	int            idle_cycles = 0;

	sorted_table_binary_search_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.load_index (load_index),
		.value      (value),
		.done       (done),
		.found      (found),
		.position   (position),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			hits.check_result(found, position);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || (cfg_valid && cfg_ready) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_word(input logic act, input logic [LIDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] val);
		if (!start)
			start <= 1'b1;
		action     <= act;
		load_index <= idx;
		value      <= val;
		do @(posedge clk); while (busy);
		hits.note_word(act, idx, val);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	// hold off until every search has answered and the block is quiet
	task automatic drain_idle();
		if (start)
			start <= 1'b0;
		do @(posedge clk); while (hits.pending() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_count(input logic [CFG_W-1:0] c);
		drain_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		hits.set_count(c);
	endtask

	task automatic fill_sorted(input int n);
		longint cur;
		longint step_max;
		cur = VAL_MIN;
		if ($urandom_range(0, 1) != 0)
			cur = cur + longint'($urandom_range(0, 1 << 30));
		step_max = ($urandom_range(0, 3) == 0) ? 2 : (64'sd4294967296 / n);
		for (int i = 0; i < n; i++) begin
			if (i == n - 1 && $urandom_range(0, 2) == 0)
				cur = VAL_MAX;
			send_word(ACT_LOAD, i[LIDX_W-1:0], cur[DATA_W-1:0]);
			cur = cur + longint'($urandom_range(0, int'(step_max)));
			if (cur > VAL_MAX)
				cur = VAL_MAX;
		end
	endtask

	function automatic logic signed [DATA_W-1:0] sparse_val(input int i);
		longint v;
		v = VAL_MIN + longint'(i) * SPARSE_STEP;
		return v[DATA_W-1:0];
	endfunction

	// load every entry that the search for key will read and that is not yet written
	task automatic load_path(input logic signed [DATA_W-1:0] key, input int n);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = n - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (!hits.written[mid])
				send_word(ACT_LOAD, mid[LIDX_W-1:0], sparse_val(mid));
			if (hits.table_copy[mid] == key)
				return;
			if (hits.table_copy[mid] < key)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_key(input int n);
		logic signed [DATA_W-1:0] k;
		int                       sel;
		int                       idx;
		sel = $urandom_range(0, 9);
		k   = $urandom;
		if (n > 0 && sel <= 6) begin
			idx = $urandom_range(0, n - 1);
			k   = hits.written[idx] ? hits.table_copy[idx] : sparse_val(idx);
			if (sel == 5)
				k = k + 1;
			else if (sel == 6)
				k = k - 1;
		end else if (sel == 8) begin
			k = VAL_MIN[DATA_W-1:0];
		end else if (sel == 9) begin
			k = VAL_MAX[DATA_W-1:0];
		end
		return k;
	endfunction

	initial begin
		int n;
		int n_eff;
		bit refill;
		logic signed [DATA_W-1:0] key;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(ACT_SEARCH, '0, '0);
		send_word(ACT_SEARCH, '1, VAL_MIN[DATA_W-1:0]);
		send_word(ACT_SEARCH, '0, VAL_MAX[DATA_W-1:0]);
		send_word(ACT_LOAD, 10'd0, VAL_MIN[DATA_W-1:0]);
		send_word(ACT_LOAD, 10'd1, -32'sd5);
		send_word(ACT_LOAD, 10'd2, 32'sd7);
		send_word(ACT_LOAD, 10'd3, VAL_MAX[DATA_W-1:0]);
		send_word(ACT_LOAD, 10'd1023, 32'sh5A5A5A5A);
		write_count(11'd4);
		send_word(ACT_SEARCH, '0, VAL_MIN[DATA_W-1:0]);
		send_word(ACT_SEARCH, '0, -32'sd5);
		send_word(ACT_SEARCH, '0, 32'sd7);
		send_word(ACT_SEARCH, '0, VAL_MAX[DATA_W-1:0]);
		send_word(ACT_SEARCH, '0, 32'sd0);
		send_word(ACT_SEARCH, '0, 32'sd6);
		send_word(ACT_SEARCH, '0, VAL_MIN[DATA_W-1:0] + 1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			refill = 1'b1;
			case (p)
				0: n = 0;
				1: n = 1;
				2: n = 2;
				3: begin
					n = 1024;
					refill = 1'b0;
				end
				4: begin
					n = 2047;
					refill = 1'b0;
				end
				5: begin
					n = 1100;
					refill = 1'b0;
				end
				6: begin
					n = 1023;
					refill = 1'b0;
				end
				default: n = $urandom_range(3, 20);
			endcase
			write_count(n[CFG_W-1:0]);
			n_eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
			if (refill && n_eff > 0)
				fill_sorted(n_eff);
			repeat (SEARCHES_PER) begin
				if ($urandom_range(0, 9) == 0) begin
					send_word(ACT_LOAD, LIDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
						$urandom);
				end else begin
					key = pick_key(n_eff);
					load_path(key, n_eff);
					send_word(ACT_SEARCH, LIDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
						key);
				end
			end
		end

		drain_idle();
		if (hits.errors == 0 && hits.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
design/stbs_pkg.sv
design/stbs_dpath.sv
design/stbs_ctrl.sv
design/sorted_table_binary_search_top.sv
sim/tb_sorted_table_binary_search_top.sv
